// ----- sv/rfa_pkg.sv -----
// Package for the rational fraction ALU: payload structs, commands, controller states.
// Used by every module of the block; depends on nothing.
package rfa_pkg;

  localparam int WordBits = 64;
  localparam int HalfBits = WordBits / 2;
  localparam int CntBits  = 7;

  typedef logic [WordBits-1:0] word_t;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_NEG = 3'd3,
    CMD_RCP = 3'd4,
    CMD_RED = 3'd5,
    CMD_RS6 = 3'd6,
    CMD_RS7 = 3'd7
  } cmd_t;

  typedef struct packed {
    logic [2:0]          command;
    logic [WordBits-1:0] a_num;
    logic [WordBits-1:0] a_den;
    logic [WordBits-1:0] b_num;
    logic [WordBits-1:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic [WordBits-1:0] res_num;
    logic [WordBits-1:0] res_den;
    logic                undefined;
  } out_item_t;

  // Datapath operation selects, issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL0,
    OP_MUL1,
    OP_MUL2,
    OP_COMB,
    OP_PREP,
    OP_DIVSTEP,
    OP_GCDSWAP,
    OP_QN_INIT,
    OP_QD_INIT,
    OP_QN_DONE,
    OP_FINAL
  } op_t;

  typedef struct packed {
    op_t op;
  } rfa_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic num_zero;
    logic rem_zero;
    logic cnt_done;
    logic mul_last;
  } rfa_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_COMB,
    ST_PREP,
    ST_GCD,
    ST_GCDNEXT,
    ST_QN,
    ST_QD,
    ST_FINAL,
    ST_OUT
  } state_t;

endpackage

// ----- sv/rational_fraction_alu_unit.sv -----
// Rational fraction ALU: one command on two fractions, one normalized fraction out.
// A zero numerator or denominator skips the gcd; other results wait on the gcd remainder
// steps and the quotient divisions of the radix-2 divider.
// One beat is worked on at a time; the next can be taken in the cycle after the result leaves.
// Reset (rst_n, synchronous) returns to idle. Depends on rfa_pkg, rfa_ctrl, rfa_datapath.
module rational_fraction_alu_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rfa_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rfa_pkg::out_item_t out_data
);
  import rfa_pkg::*;

  rfa_cmd_t  cmd;
  rfa_stat_t stat;

  rfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rfa_datapath u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .in_data (in_data),
    .stat    (stat),
    .out_data(out_data)
  );

endmodule

// ----- sv/rfa_datapath.sv -----
// Datapath of the rational fraction ALU: operand registers, one shared 32x32 multiplier
// used in three passes per product, a restoring radix-2 divider for gcd and quotients.
// Depends on rfa_pkg.
module rfa_datapath (
  input  logic               clk,
  input  rfa_pkg::rfa_cmd_t  cmd,
  input  rfa_pkg::in_item_t  in_data,
  output rfa_pkg::rfa_stat_t stat,
  output rfa_pkg::out_item_t out_data
);
  import rfa_pkg::*;

  cmd_t               cmd_r;
  word_t              an_r, ad_r, bn_r, bd_r;
  word_t              p0_r, p1_r, n_r, d_r, acc_r;
  word_t              y_r, mn_r, md_r, g_r;
  word_t              quo_r, rem_r, dvd_r, dvs_r;
  logic               neg_r;
  logic [CntBits-1:0] cnt_r;
  out_item_t          res_r;

  word_t               mul_a, mul_b, pp, mul_sum;
  logic [HalfBits-1:0] pa, pb;
  logic                mul_last;
  logic [WordBits:0]   trial;
  word_t               rem_sh;
  word_t               qn_w, qv_w;

  // Operand select and one half-by-half partial product per cycle.
  // Pass 0 takes low*low, pass 1 adds low*high, pass 2 adds high*low.
  always_comb begin
    mul_a = an_r;
    mul_b = bd_r;
    case (cmd.op)
      OP_MUL0: begin mul_a = ad_r; mul_b = bd_r; end
      OP_MUL1: begin
        mul_a = an_r;
        mul_b = (cmd_r == CMD_MUL) ? bn_r : bd_r;
      end
      OP_MUL2: begin mul_a = bn_r; mul_b = ad_r; end
      default: begin mul_a = an_r; mul_b = bd_r; end
    endcase
    if (cnt_r == '0) begin
      pa = mul_a[HalfBits-1:0];
      pb = mul_b[HalfBits-1:0];
    end else if (cnt_r == CntBits'(1)) begin
      pa = mul_a[HalfBits-1:0];
      pb = mul_b[WordBits-1:HalfBits];
    end else begin
      pa = mul_a[WordBits-1:HalfBits];
      pb = mul_b[HalfBits-1:0];
    end
    pp      = word_t'(pa) * word_t'(pb);
    mul_sum = acc_r + {pp[HalfBits-1:0], HalfBits'(0)};
  end

  assign mul_last = (cnt_r == CntBits'(2));

  // One restoring division step.
  always_comb begin
    rem_sh = {rem_r[WordBits-2:0], dvd_r[WordBits-1]};
    trial  = {rem_r, dvd_r[WordBits-1]} - {1'b0, dvs_r};
  end

  assign qn_w = neg_r ? (word_t'(0) - quo_r) : quo_r;
  assign qv_w = quo_r;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        cmd_r <= cmd_t'(in_data.command);
        an_r  <= in_data.a_num;
        ad_r  <= in_data.a_den;
        bn_r  <= in_data.b_num;
        bd_r  <= in_data.b_den;
        cnt_r <= '0;
      end
      OP_MUL0, OP_MUL1, OP_MUL2: begin
        if (mul_last) begin
          cnt_r <= '0;
          case (cmd.op)
            OP_MUL0: d_r  <= mul_sum;
            OP_MUL1: p0_r <= mul_sum;
            default: p1_r <= mul_sum;
          endcase
        end else begin
          acc_r <= (cnt_r == '0) ? pp : mul_sum;
          cnt_r <= cnt_r + CntBits'(1);
        end
      end
      OP_COMB: begin
        unique case (cmd_r)
          CMD_ADD: n_r <= p0_r + p1_r;
          CMD_SUB: n_r <= p0_r - p1_r;
          CMD_MUL: n_r <= p0_r;
          CMD_NEG: begin n_r <= word_t'(0) - an_r; d_r <= ad_r; end
          CMD_RCP: begin n_r <= ad_r; d_r <= an_r; end
          default: begin n_r <= an_r; d_r <= ad_r; end
        endcase
      end
      OP_PREP: begin
        neg_r <= n_r[WordBits-1] ^ d_r[WordBits-1];
        mn_r  <= n_r[WordBits-1] ? word_t'(0) - n_r : n_r;
        md_r  <= d_r[WordBits-1] ? word_t'(0) - d_r : d_r;
        y_r   <= d_r[WordBits-1] ? word_t'(0) - d_r : d_r;
        dvd_r <= n_r[WordBits-1] ? word_t'(0) - n_r : n_r;
        dvs_r <= d_r[WordBits-1] ? word_t'(0) - d_r : d_r;
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= '0;
      end
      OP_DIVSTEP: begin
        if (!trial[WordBits]) begin
          rem_r <= trial[WordBits-1:0];
          quo_r <= {quo_r[WordBits-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[WordBits-2:0], 1'b0};
        end
        dvd_r <= {dvd_r[WordBits-2:0], 1'b0};
        cnt_r <= cnt_r + CntBits'(1);
      end
      OP_GCDSWAP: begin
        // y <- x mod y; start next remainder.
        y_r   <= rem_r;
        g_r   <= y_r;
        dvd_r <= y_r;
        dvs_r <= rem_r;
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= '0;
      end
      OP_QN_INIT: begin
        // The last nonzero divisor is the gcd.
        g_r   <= y_r;
        dvd_r <= mn_r;
        dvs_r <= y_r;
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= '0;
      end
      OP_QN_DONE: begin
        n_r   <= qn_w;
        dvd_r <= md_r;
        dvs_r <= g_r;
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= '0;
      end
      OP_FINAL: begin
        if (d_r == '0) begin
          res_r.res_num   <= n_r;
          res_r.res_den   <= '0;
          res_r.undefined <= 1'b1;
        end else if (n_r == '0) begin
          res_r.res_num   <= '0;
          res_r.res_den   <= word_t'(1);
          res_r.undefined <= 1'b0;
        end else begin
          res_r.res_num   <= n_r;
          res_r.res_den   <= qv_w;
          res_r.undefined <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign stat.den_zero = (d_r == '0);
  assign stat.num_zero = (n_r == '0);
  assign stat.rem_zero = (rem_r == '0);
  assign stat.cnt_done = (cnt_r == CntBits'(WordBits));
  assign stat.mul_last = mul_last;
  assign out_data      = res_r;

endmodule

// ----- sv/rfa_ctrl.sv -----
// Controller of the rational fraction ALU: sequences load, multiplies, gcd and
// quotient divisions, and owns both handshakes. Depends on rfa_pkg.
module rfa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  rfa_pkg::rfa_stat_t stat,
  output rfa_pkg::rfa_cmd_t  cmd
);
  import rfa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath command.
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_MUL0;
        end
      end
      // Each product takes three multiplier passes.
      ST_MUL0: begin
        cmd.op = OP_MUL0;
        if (stat.mul_last) begin
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.op = OP_MUL1;
        if (stat.mul_last) begin
          state_nxt = ST_MUL2;
        end
      end
      ST_MUL2: begin
        cmd.op = OP_MUL2;
        if (stat.mul_last) begin
          state_nxt = ST_COMB;
        end
      end
      ST_COMB:  begin cmd.op = OP_COMB; state_nxt = ST_PREP; end
      ST_PREP: begin
        // Zero cases skip the gcd entirely; FINAL reads the flags.
        if (stat.den_zero || stat.num_zero) begin
          state_nxt = ST_FINAL;
        end else begin
          cmd.op    = OP_PREP;
          state_nxt = ST_GCD;
        end
      end
      ST_GCD: begin
        if (stat.cnt_done) begin
          state_nxt = ST_GCDNEXT;
        end else begin
          cmd.op = OP_DIVSTEP;
        end
      end
      ST_GCDNEXT: begin
        if (stat.rem_zero) begin
          cmd.op    = OP_QN_INIT;
          state_nxt = ST_QN;
        end else begin
          cmd.op    = OP_GCDSWAP;
          state_nxt = ST_GCD;
        end
      end
      ST_QN: begin
        if (stat.cnt_done) begin
          cmd.op    = OP_QN_DONE;
          state_nxt = ST_QD;
        end else begin
          cmd.op = OP_DIVSTEP;
        end
      end
      ST_QD: begin
        if (stat.cnt_done) begin
          state_nxt = ST_FINAL;
        end else begin
          cmd.op = OP_DIVSTEP;
        end
      end
      ST_FINAL: begin cmd.op = OP_FINAL; state_nxt = ST_OUT; end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid);

  // Input is never taken while a result waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && !in_stall));

  // Operands are loaded only from idle on a valid input beat.
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_LOAD) |-> (state_r == ST_IDLE) && in_valid);

  // A taken result beat returns the controller to idle.
  a_out_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> state_r == ST_IDLE);

  // The state register is always known out of reset.
  a_state_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(state_r));

endmodule
